// ----- rtl/cns_pkg.sv -----
// Shared types, constants and helpers for the cutoff neighbor search block.
package cns_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CUT_W   = 34;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SQ_W    = 2 * COORD_W;

  localparam logic [COORD_W:0] FULL_BOX = 17'h10000;
  localparam logic [COORD_W-1:0] HALF_BOX = 16'h8000;
  localparam logic [IDX_W-1:0] TOTAL_MAX = 10'd1023;

  // register indexes
  localparam logic [1:0] REG_CUTOFF   = 2'd0;
  localparam logic [1:0] REG_NODES    = 2'd1;
  localparam logic [1:0] REG_PERIODIC = 2'd2;

  localparam logic [CUT_W-1:0] CUTOFF_RST = 34'd43811161;
  localparam logic [CNT_W-1:0] NODES_RST  = 11'd1000;

  // request and result kinds
  localparam logic REQ_STORE    = 1'b0;
  localparam logic REQ_QUERY    = 1'b1;
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [CUT_W-1:0] cutoff_squared;
    logic [CNT_W-1:0] node_count;
    logic             periodic_mode;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  // absolute axis difference, minimum image when wrap is set
  function automatic logic [COORD_W-1:0] axis_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic wrap);
    logic [COORD_W-1:0] d;
    logic [COORD_W:0]   w;
    d = (a > b) ? (a - b) : (b - a);
    w = FULL_BOX - {1'b0, d};
    if (wrap && (d > HALF_BOX)) begin
      d = w[COORD_W-1:0];
    end
    return d;
  endfunction

endpackage

// ----- rtl/cns_ram.sv -----
// Generic single-clock RAM: one write port, one registered read port.
module cns_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cns_regs.sv -----
// APB configuration registers of the neighbor search block.
module cns_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output cns_pkg::cfg_t       cfg
);
  import cns_pkg::*;

  logic [1:0] reg_sel;
  logic       wr;

  assign reg_sel = paddr[4:3];
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_squared <= CUTOFF_RST;
      cfg.node_count     <= NODES_RST;
      cfg.periodic_mode  <= 1'b0;
    end else if (wr) begin
      case (reg_sel)
        REG_CUTOFF:   cfg.cutoff_squared <= pwdata[CUT_W-1:0];
        REG_NODES:    cfg.node_count     <= pwdata[CNT_W-1:0];
        REG_PERIODIC: cfg.periodic_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CUTOFF:   prdata = {{(64-CUT_W){1'b0}}, cfg.cutoff_squared};
      REG_NODES:    prdata = {{(64-CNT_W){1'b0}}, cfg.node_count};
      REG_PERIODIC: prdata = {63'd0, cfg.periodic_mode};
      default:      prdata = 64'd0;
    endcase
  end

endmodule

// ----- rtl/cns_dist.sv -----
// Three-stage squared-distance and cutoff compare pipeline.
module cns_dist #(
  parameter int unsigned TAG_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [TAG_W-1:0]    in_tag,
  input  cns_pkg::point_t     ref_pt,
  input  cns_pkg::point_t     cand_pt,
  input  logic                wrap,
  input  logic [33:0]         cutoff_squared,
  output logic                hit,
  output logic [TAG_W-1:0]    hit_tag,
  output logic                busy
);
  import cns_pkg::*;

  logic               v1, v2, v3;
  logic [TAG_W-1:0]   t1, t2;
  logic [COORD_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]    sx, sy, sz;
  logic [CUT_W-1:0]   d2;

  assign d2   = CUT_W'(sx) + CUT_W'(sy) + CUT_W'(sz);
  assign busy = v1 || v2 || v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2 && (d2 < cutoff_squared);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx      <= axis_diff(ref_pt.x, cand_pt.x, wrap);
      dy      <= axis_diff(ref_pt.y, cand_pt.y, wrap);
      dz      <= axis_diff(ref_pt.z, cand_pt.z, wrap);
      t1      <= in_tag;
      sx      <= dx * dx;
      sy      <= dy * dy;
      sz      <= dz * dz;
      t2      <= t1;
      hit_tag <= t2;
    end
  end

  assign hit = v3;

endmodule

// ----- rtl/cutoff_neighbor_search.sv -----
// Top level of the cutoff neighbor search block: control, output stage, wiring.
//
// Usage
//   Requests enter on the s_ group. s_tuser is the request type (store or
//   query); s_tdata carries the node index and the x, y, z coordinates.
//   A store writes one point into the point memory in the accept cycle and
//   returns nothing. A query walks every index below min(node_count, NODES),
//   skips the queried point, and returns one entry per neighbor (squared
//   distance strictly below cutoff_squared), at most MAX_LIST of them, in
//   ascending index order, then a summary with tlast set.
//   Sequencing: a store leaves the request channel ready for the next
//   request. A query holds the request channel through the reference fetch
//   (S_REF, S_LOAD), then one memory read per walked index through the single
//   read port of the point memory, then the memory read and the three-stage
//   compare pipeline drain and the summary is loaded.
//   Back-pressure: while the output register holds a result that m_tready
//   does not take, the whole walk freezes, memory read included, and resumes
//   without loss. A new request is taken as soon as the summary sits in the
//   output register.
//   Reset clears control state and loads register defaults. The point memory
//   is not cleared; a query must only read points that were stored.
//   Configuration goes through the APB port at byte addresses 0, 8 and 16.
module cutoff_neighbor_search #(
  parameter int unsigned NODES    = 1024,
  parameter int unsigned MAX_LIST = 10
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // node_index[9:0], x[25:10], y[41:26], z[57:42], zero pad
  input  logic        s_tuser,   // req_type
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // neighbor_index[9:0], neighbor_total[19:10],
                                 // list_truncated[20], zero pad
  output logic        m_tuser,   // result_kind
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cns_pkg::*;

  localparam int unsigned AW = $clog2(NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REF  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  cfg_t cfg;

  logic [1:0]       state;
  logic [AW:0]      rd_addr;
  logic [AW:0]      limit;
  logic [IDX_W-1:0] qidx;
  logic [IDX_W-1:0] count;
  logic             wrap;
  point_t           ref_pt;
  point_t           rdata;
  logic             p0_valid;
  logic [AW-1:0]    p0_tag;

  // request fields
  logic [IDX_W-1:0] in_idx;
  point_t           in_pt;
  logic             accept;
  logic             in_idx_ok;
  logic [12:0]      lim13;
  logic [12:0]      nodes13;
  logic [12:0]      in_idx13;

  // pipeline control
  logic             out_free;
  logic             adv;
  logic             issuing;
  logic             skip_self;
  logic             hit;
  logic [AW-1:0]    hit_tag;
  logic [12:0]      hit_tag13;
  logic             busy;
  logic             walk_done;
  logic             load_entry;
  logic             load_summary;

  // output register
  logic             out_valid;
  logic             out_kind;
  logic [IDX_W-1:0] out_nidx;
  logic [IDX_W-1:0] out_total;
  logic             out_trunc;
  logic             out_last;

  assign in_idx    = s_tdata[9:0];
  assign in_pt.x   = s_tdata[25:10];
  assign in_pt.y   = s_tdata[41:26];
  assign in_pt.z   = s_tdata[57:42];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign nodes13   = 13'(NODES);
  assign in_idx13  = {3'd0, in_idx};
  assign in_idx_ok = in_idx13 < nodes13;

  // walk length: node_count saturated to NODES, nothing for an index off the store
  always_comb begin
    if (!in_idx_ok) begin
      lim13 = 13'd0;
    end else if ({2'd0, cfg.node_count} > nodes13) begin
      lim13 = nodes13;
    end else begin
      lim13 = {2'd0, cfg.node_count};
    end
  end

  // only the walk stalls on the output; the reference fetch must not be frozen
  assign out_free  = !out_valid || m_tready;
  assign adv       = (state != S_WALK) || out_free;
  assign issuing   = rd_addr < limit;
  assign skip_self = 13'(rd_addr) == {3'd0, qidx};
  assign walk_done = (state == S_WALK) && !issuing && !p0_valid && !busy;

  assign load_entry   = (state == S_WALK) && out_free && hit &&
                        (count < IDX_W'(MAX_LIST));
  assign load_summary = walk_done && out_free;
  assign hit_tag13    = 13'(hit_tag);

  cns_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cns_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (NODES)
  ) u_points (
    .clk   (clk),
    .we    (accept && (s_tuser == REQ_STORE) && in_idx_ok),
    .waddr (in_idx13[AW-1:0]),
    .wdata (in_pt),
    .re    (adv),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  cns_dist #(
    .TAG_W (AW)
  ) u_dist (
    .clk            (clk),
    .rst            (rst),
    .en             (out_free),
    .in_valid       (p0_valid),
    .in_tag         (p0_tag),
    .ref_pt         (ref_pt),
    .cand_pt        (rdata),
    .wrap           (wrap),
    .cutoff_squared (cfg.cutoff_squared),
    .hit            (hit),
    .hit_tag        (hit_tag),
    .busy           (busy)
  );

  // sequencer: fetch reference point, then issue one read per index
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p0_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (s_tuser == REQ_QUERY)) begin
            state <= S_REF;
          end
        end
        S_REF: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          p0_valid <= issuing && !skip_self;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (out_free) begin
            p0_valid <= issuing && !skip_self;
          end
          if (load_summary) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          rd_addr <= in_idx13[AW:0];
          qidx    <= in_idx;
          limit   <= lim13[AW:0];
          wrap    <= cfg.periodic_mode;
          count   <= '0;
        end
      end
      S_REF: begin
        rd_addr <= '0;
      end
      S_LOAD: begin
        ref_pt  <= rdata;
        p0_tag  <= rd_addr[AW-1:0];
        if (issuing) begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
      S_WALK: begin
        if (out_free) begin
          p0_tag <= rd_addr[AW-1:0];
          if (issuing) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (hit && (count != TOTAL_MAX)) begin
            count <= count + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_entry || load_summary) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_kind  <= KIND_ENTRY;
      out_nidx  <= hit_tag13[IDX_W-1:0];
      out_total <= '0;
      out_trunc <= 1'b0;
      out_last  <= 1'b0;
    end else if (load_summary) begin
      out_kind  <= KIND_SUMMARY;
      out_nidx  <= '0;
      out_total <= count;
      out_trunc <= count > IDX_W'(MAX_LIST);
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'd0, out_trunc, out_total, out_nidx};

`ifndef SYNTH
  // no compare work left over once a new request can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!p0_valid && !busy))
    else $error("pipeline busy while idle");

  // read pointer never runs past the walk length
  a_addr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (rd_addr <= limit))
    else $error("read address beyond walk limit");

  // entry and summary never compete for the output register
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(load_entry && load_summary))
    else $error("entry and summary loaded together");

  // a summary flags truncation exactly when the count is above the list size
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[20] == (m_tdata[19:10] > IDX_W'(MAX_LIST))))
    else $error("truncation flag disagrees with total");
`endif

endmodule
